// File: rtl/core/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg: shared definitions for the first-fit free-list allocator
// Port widths, command and status codes, default heap geometry and the
// command/status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int unsigned DEF_HEAP_BYTES   = 1024;
  localparam int unsigned DEF_HEADER_BYTES = 24;
  localparam int unsigned DEF_ALIGN_BYTES  = 8;

  localparam int CMD_W    = 2;
  localparam int REQ_W    = 11;
  localparam int ADDR_W   = 10;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_INIT,
    OP_ALLOC_DIV,
    OP_NEED,
    OP_READ_CUR,
    OP_STEP,
    OP_FIT,
    OP_SPLIT_NEW,
    OP_SPLIT_LINK,
    OP_UNLINK_PREV,
    OP_UNLINK_CUR,
    OP_FREE_DIV,
    OP_FREE_WRITE,
    OP_RESULT
  } ffa_op_t;

  typedef struct packed {
    ffa_op_t             op;
    logic [STATUS_W-1:0] res_status;
    logic                res_addr;
  } ffa_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             req_zero;
    logic             fad_low;
    logic             walk_end;
    logic             fit;
    logic             walk_last;
    logic             split_ok;
    logic             slot_bad;
  } ffa_stat_t;

endpackage

// File: rtl/core/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl: allocator sequencer
// Decodes each command and steps the datapath through init, the first-fit
// walk with split or unlink, and free; raises done for one cycle per result.
// ----------------------------------------------------------------------------
module ffa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  output ffa_pkg::ffa_cmd_t   ctrl,
  input  ffa_pkg::ffa_stat_t  stat
);
  import ffa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_A_WAIT,
    S_A_NEED,
    S_CHECK,
    S_EVAL,
    S_F_WAIT,
    S_F_DEC,
    S_SPLIT1,
    S_SPLIT2,
    S_UNLINK1,
    S_UNLINK2,
    S_FR_WAIT,
    S_FR_WRITE,
    S_FINISH,
    S_FINISH_ADDR
  } state_t;

  state_t state, state_next;
  logic   done_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    ctrl.op         = OP_NONE;
    ctrl.res_status = ST_OK;
    ctrl.res_addr   = 1'b0;
    state_next      = state;
    done_next       = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.op    = OP_CAPTURE;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.cmd)
          CMD_INIT: begin
            ctrl.op    = OP_INIT;
            state_next = S_FINISH;
          end
          CMD_ALLOC: begin
            if (stat.req_zero) begin
              ctrl.op         = OP_RESULT;
              ctrl.res_status = ST_ZERO;
              done_next       = 1'b1;
              state_next      = S_IDLE;
            end else begin
              ctrl.op    = OP_ALLOC_DIV;
              state_next = S_A_WAIT;
            end
          end
          CMD_FREE: begin
            if (stat.fad_low) begin
              state_next = S_FINISH;
            end else begin
              ctrl.op    = OP_FREE_DIV;
              state_next = S_FR_WAIT;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_A_WAIT: begin
        state_next = S_A_NEED;
      end
      S_A_NEED: begin
        ctrl.op    = OP_NEED;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.walk_end) begin
          ctrl.op         = OP_RESULT;
          ctrl.res_status = ST_NOFIT;
          done_next       = 1'b1;
          state_next      = S_IDLE;
        end else begin
          ctrl.op    = OP_READ_CUR;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.fit) begin
          ctrl.op    = OP_FIT;
          state_next = S_F_WAIT;
        end else if (stat.walk_last) begin
          ctrl.op         = OP_RESULT;
          ctrl.res_status = ST_NOFIT;
          done_next       = 1'b1;
          state_next      = S_IDLE;
        end else begin
          ctrl.op = OP_STEP;
        end
      end
      S_F_WAIT: begin
        state_next = S_F_DEC;
      end
      S_F_DEC: begin
        state_next = stat.split_ok ? S_SPLIT1 : S_UNLINK1;
      end
      S_SPLIT1: begin
        ctrl.op    = OP_SPLIT_NEW;
        state_next = S_SPLIT2;
      end
      S_SPLIT2: begin
        ctrl.op    = OP_SPLIT_LINK;
        state_next = S_FINISH_ADDR;
      end
      S_UNLINK1: begin
        ctrl.op    = OP_UNLINK_PREV;
        state_next = S_UNLINK2;
      end
      S_UNLINK2: begin
        ctrl.op    = OP_UNLINK_CUR;
        state_next = S_FINISH_ADDR;
      end
      S_FR_WAIT: begin
        state_next = S_FR_WRITE;
      end
      S_FR_WRITE: begin
        if (!stat.slot_bad) begin
          ctrl.op = OP_FREE_WRITE;
        end
        state_next = S_FINISH;
      end
      S_FINISH: begin
        ctrl.op    = OP_RESULT;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      S_FINISH_ADDR: begin
        ctrl.op       = OP_RESULT;
        ctrl.res_addr = 1'b1;
        done_next     = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // A result strobe lasts a single cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // Every result closes a transaction that was in progress.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("done without a transaction in progress");

  // Accepting a command always starts work.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted command did not start");

endmodule

// File: rtl/core/ffa_datapath.sv
// ----------------------------------------------------------------------------
// ffa_datapath: header store, list pointers and arithmetic
// Holds the per-slot header memories (size, offset, successor), the list
// head, the walk registers and a constant divider by the alignment.
// ----------------------------------------------------------------------------
module ffa_datapath #(
  parameter int unsigned HEAP_BYTES   = ffa_pkg::DEF_HEAP_BYTES,
  parameter int unsigned HEADER_BYTES = ffa_pkg::DEF_HEADER_BYTES,
  parameter int unsigned ALIGN_BYTES  = ffa_pkg::DEF_ALIGN_BYTES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ffa_pkg::ffa_cmd_t               ctrl,
  output ffa_pkg::ffa_stat_t              stat,
  input  logic [ffa_pkg::CMD_W-1:0]       cmd,
  input  logic [ffa_pkg::REQ_W-1:0]       request_size,
  input  logic [ffa_pkg::ADDR_W-1:0]      free_address,
  output logic [ffa_pkg::ADDR_W-1:0]      address,
  output logic [ffa_pkg::STATUS_W-1:0]    status
);
  import ffa_pkg::*;

  localparam int unsigned SLOTS = HEAP_BYTES / ALIGN_BYTES;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int NEXT_W = $clog2(SLOTS + 1);
  localparam int OFF_W  = $clog2(HEAP_BYTES);
  localparam int SIZE_W = $clog2(HEAP_BYTES + 1);
  localparam int VAL_W  = $clog2(HEAP_BYTES + 4096) + 1;
  localparam int DIV_S  = VAL_W;
  localparam int unsigned DIV_M = (32'd1 << DIV_S) / ALIGN_BYTES;

  localparam logic [NEXT_W-1:0] NIL         = NEXT_W'(SLOTS);
  localparam logic [VAL_W-1:0]  HDR_V       = VAL_W'(HEADER_BYTES);
  localparam logic [VAL_W-1:0]  ALIGN_V     = VAL_W'(ALIGN_BYTES);
  localparam logic [VAL_W-1:0]  HEAP_V      = VAL_W'(HEAP_BYTES);
  localparam logic [VAL_W-1:0]  SLOTS_V     = VAL_W'(SLOTS);
  localparam logic [VAL_W-1:0]  SPLIT_MIN_V = VAL_W'(HEADER_BYTES + ALIGN_BYTES);
  localparam logic [DIV_S-1:0]  DIV_M_V     = DIV_S'(DIV_M);

  // Header store, one entry per alignment slot.
  logic [SIZE_W-1:0] size_mem [SLOTS];
  logic [OFF_W-1:0]  off_mem  [SLOTS];
  logic [NEXT_W-1:0] next_mem [SLOTS];

  logic [CMD_W-1:0]  cmd_r;
  logic [REQ_W-1:0]  req_r;
  logic [ADDR_W-1:0] fad_r;
  logic [VAL_W-1:0]  need;
  logic [NEXT_W-1:0] head, cur, prev, steps;
  logic [OFF_W-1:0]  hit_off;
  logic [NEXT_W-1:0] hit_next;
  logic [SIZE_W-1:0] excess;
  logic [VAL_W-1:0]  div_x;
  logic [VAL_W+DIV_S-1:0] div_prod;

  logic [SIZE_W-1:0] rd_size;
  logic [OFF_W-1:0]  rd_off;
  logic [NEXT_W-1:0] rd_next;

  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic              size_we, off_we, next_we;
  logic [SLOT_W-1:0] size_wa, off_wa, next_wa;
  logic [SIZE_W-1:0] size_wd;
  logic [OFF_W-1:0]  off_wd;
  logic [NEXT_W-1:0] next_wd;

  logic [VAL_W-1:0]  div_q0, div_r0, div_q, div_r;
  logic              div_fix;
  logic [VAL_W-1:0]  init_total, noff;
  logic              init_ok;
  logic [NEXT_W:0]   steps_inc;

  // Division by the alignment: reciprocal product, then one correction step.
  assign div_q0  = div_prod[VAL_W+DIV_S-1 -: VAL_W];
  assign div_r0  = div_x - VAL_W'(div_q0 * ALIGN_V);
  assign div_fix = (div_r0 >= ALIGN_V);
  assign div_q   = div_q0 + VAL_W'(div_fix);
  assign div_r   = div_fix ? (div_r0 - ALIGN_V) : div_r0;

  assign init_total = (VAL_W'(req_r) > HEAP_V) ? HEAP_V : VAL_W'(req_r);
  assign init_ok    = (init_total >= HDR_V);
  assign noff       = VAL_W'(rd_off) + HDR_V + need;
  assign steps_inc  = (NEXT_W+1)'(steps) + (NEXT_W+1)'(1);

  always_comb begin
    stat.cmd       = cmd_r;
    stat.req_zero  = (req_r == '0);
    stat.fad_low   = (VAL_W'(fad_r) < HDR_V);
    stat.walk_end  = (cur >= NIL);
    stat.fit       = (VAL_W'(rd_size) >= need);
    stat.walk_last = (steps_inc >= (NEXT_W+1)'(SLOTS)) || (rd_next >= NIL);
    stat.split_ok  = (VAL_W'(excess) >= SPLIT_MIN_V) && (div_q < SLOTS_V);
    stat.slot_bad  = (div_q >= SLOTS_V);
  end

  assign rd_en   = (ctrl.op == OP_READ_CUR) || (ctrl.op == OP_STEP);
  assign rd_addr = (ctrl.op == OP_STEP) ? rd_next[SLOT_W-1:0] : cur[SLOT_W-1:0];

  always_comb begin
    size_we = 1'b0;
    size_wa = '0;
    size_wd = '0;
    off_we  = 1'b0;
    off_wa  = '0;
    off_wd  = '0;
    next_we = 1'b0;
    next_wa = '0;
    next_wd = NIL;
    case (ctrl.op)
      OP_INIT: begin
        size_we = init_ok;
        size_wd = SIZE_W'(init_total - HDR_V);
        off_we  = init_ok;
        next_we = init_ok;
      end
      OP_SPLIT_NEW: begin
        size_we = 1'b1;
        size_wa = div_q[SLOT_W-1:0];
        size_wd = SIZE_W'(VAL_W'(excess) - HDR_V);
        off_we  = 1'b1;
        off_wa  = div_q[SLOT_W-1:0];
        off_wd  = div_x[OFF_W-1:0];
        next_we = 1'b1;
        next_wa = div_q[SLOT_W-1:0];
        next_wd = hit_next;
      end
      OP_SPLIT_LINK: begin
        size_we = 1'b1;
        size_wa = cur[SLOT_W-1:0];
        size_wd = SIZE_W'(need);
        next_we = (prev != NIL);
        next_wa = prev[SLOT_W-1:0];
        next_wd = NEXT_W'(div_q);
      end
      OP_UNLINK_PREV: begin
        next_we = (prev != NIL);
        next_wa = prev[SLOT_W-1:0];
        next_wd = hit_next;
      end
      OP_UNLINK_CUR: begin
        next_we = 1'b1;
        next_wa = cur[SLOT_W-1:0];
        next_wd = NIL;
      end
      OP_FREE_WRITE: begin
        off_we  = 1'b1;
        off_wa  = div_q[SLOT_W-1:0];
        off_wd  = div_x[OFF_W-1:0];
        next_we = 1'b1;
        next_wa = div_q[SLOT_W-1:0];
        next_wd = head;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[size_wa] <= size_wd;
    end
    if (off_we) begin
      off_mem[off_wa] <= off_wd;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (rd_en) begin
      rd_size <= size_mem[rd_addr];
      rd_off  <= off_mem[rd_addr];
      rd_next <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= NIL;
    end else begin
      case (ctrl.op)
        OP_INIT: begin
          head <= init_ok ? '0 : NIL;
        end
        OP_SPLIT_LINK: begin
          if (prev == NIL) begin
            head <= NEXT_W'(div_q);
          end
        end
        OP_UNLINK_PREV: begin
          if (prev == NIL) begin
            head <= hit_next;
          end
        end
        OP_FREE_WRITE: begin
          head <= NEXT_W'(div_q);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    div_prod <= div_x * DIV_M_V;
    case (ctrl.op)
      OP_CAPTURE: begin
        cmd_r <= cmd;
        req_r <= request_size;
        fad_r <= free_address;
      end
      OP_ALLOC_DIV: begin
        div_x <= VAL_W'(req_r) + ALIGN_V - VAL_W'(1);
      end
      OP_NEED: begin
        // Rounded-up request: the padded value less its remainder.
        need  <= div_x - div_r;
        cur   <= head;
        prev  <= NIL;
        steps <= '0;
      end
      OP_STEP: begin
        prev  <= cur;
        cur   <= rd_next;
        steps <= steps_inc[NEXT_W-1:0];
      end
      OP_FIT: begin
        hit_off  <= rd_off;
        hit_next <= rd_next;
        excess   <= rd_size - SIZE_W'(need);
        div_x    <= noff;
      end
      OP_FREE_DIV: begin
        div_x <= VAL_W'(fad_r) - HDR_V;
      end
      OP_RESULT: begin
        address <= ctrl.res_addr ? ADDR_W'(VAL_W'(hit_off) + HDR_V) : '0;
        status  <= ctrl.res_status;
      end
      default: begin
      end
    endcase
  end

  // The list head is a real slot or the empty marker.
  a_head_range: assert property (@(posedge clk) disable iff (rst) head <= NIL)
    else $error("list head beyond the empty marker");

  // Size and successor writes stay inside the store.
  a_size_wa: assert property (@(posedge clk) disable iff (rst)
    size_we |-> ((SLOT_W+1)'(size_wa) < (SLOT_W+1)'(SLOTS)))
    else $error("size write outside the header store");

  a_next_w: assert property (@(posedge clk) disable iff (rst)
    next_we |-> (((SLOT_W+1)'(next_wa) < (SLOT_W+1)'(SLOTS)) && (next_wd <= NIL)))
    else $error("bad successor write");

endmodule

// File: rtl/core/first_fit_free_list_allocator.sv
// From acceptance to done nothing stalls. Alloc walks the free list, reading
// one header per cycle, so its run grows with the number of free blocks examined;
// init, no-op, free and zero-size alloc do not walk the list.
// busy is high until done rises; a new command is accepted only while busy is low.
// done is a one-cycle strobe that the receiver cannot stall.
// Reset empties the free list; the header store holds no contents until written.
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator: heap manager with an in-heap free list
// Init, first-fit alloc with block splitting, and free onto the list head,
// built as a sequencer driving a header-store datapath.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator #(
  parameter int unsigned HEAP_BYTES   = ffa_pkg::DEF_HEAP_BYTES,
  parameter int unsigned HEADER_BYTES = ffa_pkg::DEF_HEADER_BYTES,
  parameter int unsigned ALIGN_BYTES  = ffa_pkg::DEF_ALIGN_BYTES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [ffa_pkg::CMD_W-1:0]    cmd,
  input  logic [ffa_pkg::REQ_W-1:0]    request_size,
  input  logic [ffa_pkg::ADDR_W-1:0]   free_address,
  output logic                         done,
  output logic [ffa_pkg::ADDR_W-1:0]   address,
  output logic [ffa_pkg::STATUS_W-1:0] status
);
  import ffa_pkg::*;

  ffa_cmd_t  ctrl;
  ffa_stat_t stat;

  ffa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctrl  (ctrl),
    .stat  (stat)
  );

  ffa_datapath #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .cmd          (cmd),
    .request_size (request_size),
    .free_address (free_address),
    .address      (address),
    .status       (status)
  );

endmodule

// File: sim/first_fit_free_list_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_tb: self-checking bench for the heap allocator
// A directed table covers the reset state, the field extremes, every command
// and the corner cases. It is followed by random heap traffic: allocations,
// frees of live blocks, stray frees and re-initializations. Each transaction
// is predicted by a behavioral copy of the free list and checked in order.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_tb;
  import ffa_pkg::*;

  localparam int unsigned HEAP  = DEF_HEAP_BYTES;
  localparam int unsigned HDR   = DEF_HEADER_BYTES;
  localparam int unsigned ALN   = DEF_ALIGN_BYTES;
  localparam int unsigned SLOTS = HEAP / ALN;
  localparam int unsigned NIL   = SLOTS;

  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned STALL_LIMIT  = 4000;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] fad;
  } heap_cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   address;
    logic [STATUS_W-1:0] status;
  } heap_result_t;

  typedef struct packed {
    heap_cmd_t    op;
    logic         typed;
    heap_result_t result;
  } directed_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    cmd = CMD_NOP;
  logic [REQ_W-1:0]    request_size = '0;
  logic [ADDR_W-1:0]   free_address = '0;
  logic                done;
  logic [ADDR_W-1:0]   address;
  logic [STATUS_W-1:0] status;

  // Behavioral copy of the heap headers and the free list.
  int unsigned blk_off [SLOTS];
  int unsigned blk_size[SLOTS];
  int unsigned blk_next[SLOTS];
  bit          size_valid[SLOTS];
  int unsigned head_slot = NIL;

  heap_result_t      expected_responses[$];
  logic [ADDR_W-1:0] live_blocks[$];
  directed_row_t     directed_rows[$];
  heap_result_t      oldest;
  int unsigned       error_count = 0;
  int unsigned       stall_cycles = 0;

  always #5 clk = ~clk;

  first_fit_free_list_allocator i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .request_size (request_size),
    .free_address (free_address),
    .done         (done),
    .address      (address),
    .status       (status)
  );

  function automatic void relink(int unsigned prev, int unsigned slot);
    if (prev == NIL) begin
      head_slot = slot;
    end else begin
      blk_next[prev] = slot;
    end
  endfunction

  function automatic heap_result_t predict_heap_response(heap_cmd_t c);
    heap_result_t r;
    int unsigned  total, need, cur, prev, steps, excess, noff, nslot, off, slot;
    r = '0;
    case (c.cmd)
      CMD_INIT: begin
        total = c.req;
        if (total > HEAP) total = HEAP;
        if (total < HDR) begin
          head_slot = NIL;
        end else begin
          blk_off[0]    = 0;
          blk_size[0]   = total - HDR;
          blk_next[0]   = NIL;
          size_valid[0] = 1'b1;
          head_slot     = 0;
        end
      end
      CMD_ALLOC: begin
        if (c.req == 0) begin
          r.status = ST_ZERO;
        end else begin
          need     = ((c.req + ALN - 1) / ALN) * ALN;
          r.status = ST_NOFIT;
          cur      = head_slot;
          prev     = NIL;
          // The step bound keeps a looping list from hanging the walk.
          for (steps = 0; steps < SLOTS && cur < SLOTS; steps++) begin
            if (blk_size[cur] >= need) begin
              excess = blk_size[cur] - need;
              noff   = blk_off[cur] + HDR + need;
              nslot  = noff / ALN;
              if (excess >= HDR + ALN && nslot < SLOTS) begin
                blk_off[nslot]    = noff;
                blk_size[nslot]   = excess - HDR;
                blk_next[nslot]   = blk_next[cur];
                size_valid[nslot] = 1'b1;
                blk_size[cur]     = need;
                relink(prev, nslot);
              end else begin
                relink(prev, blk_next[cur]);
                blk_next[cur] = NIL;
              end
              r.address = ADDR_W'(blk_off[cur] + HDR);
              r.status  = ST_OK;
              break;
            end
            prev = cur;
            cur  = blk_next[cur];
          end
        end
      end
      CMD_FREE: begin
        if (c.fad >= HDR) begin
          off  = c.fad - HDR;
          slot = off / ALN;
          if (slot < SLOTS) begin
            blk_off[slot]  = off;
            blk_next[slot] = head_slot;
            head_slot      = slot;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Drives one transaction, holds it until accepted, and records its expected result.
  task automatic issue(input heap_cmd_t c, input logic typed, input heap_result_t want,
                       input int unsigned idle_pct);
    heap_result_t got;
    start        <= 1'b1;
    cmd          <= c.cmd;
    request_size <= c.req;
    free_address <= c.fad;
    do @(posedge clk); while (busy);
    got = predict_heap_response(c);
    expected_responses.push_back(typed ? want : got);
    if (c.cmd == CMD_INIT) live_blocks.delete();
    if (c.cmd == CMD_ALLOC && got.status == ST_OK) live_blocks.push_back(got.address);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic add_row(input logic [CMD_W-1:0] c, input int unsigned req,
                         input int unsigned fad, input logic typed,
                         input int unsigned addr, input logic [STATUS_W-1:0] st);
    directed_row_t row;
    row.op.cmd         = c;
    row.op.req         = REQ_W'(req);
    row.op.fad         = ADDR_W'(fad);
    row.typed          = typed;
    row.result.address = ADDR_W'(addr);
    row.result.status  = st;
    directed_rows.push_back(row);
  endtask

  // Mostly well-formed heap traffic: allocs, frees of live blocks, rare inits.
  task automatic random_command(output heap_cmd_t c);
    int unsigned pick, shape, idx;
    pick  = $urandom_range(0, 99);
    shape = $urandom_range(0, 99);
    c.req = REQ_W'($urandom);
    c.fad = ADDR_W'($urandom);
    if (pick < 3) begin
      c.cmd = CMD_INIT;
      if (shape < 70)      c.req = REQ_W'(HEAP);
      else if (shape < 80) c.req = REQ_W'($urandom_range(HEAP + 1, 2047));
      else if (shape < 88) c.req = REQ_W'($urandom_range(0, HDR - 1));
      else                 c.req = REQ_W'($urandom_range(HDR, HEAP - 1));
    end else if (pick < 52) begin
      c.cmd = CMD_ALLOC;
      if (shape < 5)       c.req = '0;
      else if (shape < 80) c.req = REQ_W'($urandom_range(1, 96));
      else if (shape < 95) c.req = REQ_W'($urandom_range(97, 600));
      else                 c.req = REQ_W'($urandom_range(601, 2047));
    end else if (pick < 92) begin
      c.cmd = CMD_FREE;
      if (pick < 85 && live_blocks.size() != 0) begin
        idx   = $urandom_range(0, live_blocks.size() - 1);
        c.fad = live_blocks[idx];
        live_blocks.delete(idx);
      end
      // A header that was never written must not be pushed onto the list.
      if (c.fad >= HDR && !size_valid[(c.fad - HDR) / ALN]) c.fad = ADDR_W'(c.fad % HDR);
    end else begin
      c.cmd = CMD_NOP;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_responses.size() == 0) begin
        $error("unexpected result: address %0d status %0d", address, status);
        error_count++;
      end else begin
        oldest = expected_responses.pop_front();
        if (address !== oldest.address) begin
          $error("address: expected %0d, got %0d", oldest.address, address);
          error_count++;
        end
        if (status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy && !rst) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("** first_fit_free_list_allocator: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    heap_cmd_t    c;
    heap_result_t none;
    int unsigned  idle_pct[3];
    none        = '0;
    idle_pct[0] = 0;
    idle_pct[1] = 58;
    idle_pct[2] = 25;

    // Reset state, field extremes, saturating init, a self-looping list,
    // exact fits, remainders too small to split and tiny heaps.
    add_row(CMD_ALLOC, 8,    0,    1'b1, 0,  ST_NOFIT);
    add_row(CMD_ALLOC, 0,    0,    1'b1, 0,  ST_ZERO);
    add_row(CMD_NOP,   2047, 1023, 1'b1, 0,  ST_OK);
    add_row(CMD_FREE,  0,    23,   1'b1, 0,  ST_OK);
    add_row(CMD_INIT,  2047, 0,    1'b1, 0,  ST_OK);
    add_row(CMD_ALLOC, 1,    0,    1'b1, 24, ST_OK);
    add_row(CMD_ALLOC, 2047, 0,    1'b1, 0,  ST_NOFIT);
    add_row(CMD_ALLOC, 936,  0,    1'b0, 0,  ST_OK);
    add_row(CMD_FREE,  0,    1023, 1'b1, 0,  ST_OK);
    add_row(CMD_ALLOC, 16,   0,    1'b1, 0,  ST_NOFIT);
    add_row(CMD_ALLOC, 8,    0,    1'b0, 0,  ST_OK);
    add_row(CMD_FREE,  0,    24,   1'b1, 0,  ST_OK);
    add_row(CMD_ALLOC, 8,    0,    1'b0, 0,  ST_OK);
    add_row(CMD_INIT,  23,   0,    1'b1, 0,  ST_OK);
    add_row(CMD_ALLOC, 1,    0,    1'b1, 0,  ST_NOFIT);
    add_row(CMD_INIT,  24,   0,    1'b1, 0,  ST_OK);
    add_row(CMD_ALLOC, 1,    0,    1'b1, 0,  ST_NOFIT);
    add_row(CMD_INIT,  1024, 0,    1'b1, 0,  ST_OK);
    add_row(CMD_ALLOC, 1000, 0,    1'b1, 24, ST_OK);
    add_row(CMD_ALLOC, 8,    0,    1'b1, 0,  ST_NOFIT);
    add_row(CMD_FREE,  0,    24,   1'b1, 0,  ST_OK);
    add_row(CMD_ALLOC, 969,  0,    1'b0, 0,  ST_OK);
    add_row(CMD_NOP,   0,    0,    1'b1, 0,  ST_OK);
    add_row(CMD_INIT,  64,   0,    1'b1, 0,  ST_OK);
    add_row(CMD_ALLOC, 7,    0,    1'b0, 0,  ST_OK);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      issue(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].result, 25);
    end

    for (int ph = 0; ph < 3; ph++) begin
      // Let the block drain completely before each new idling pattern.
      start <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clk);
      @(posedge clk);
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        random_command(c);
        issue(c, 1'b0, none, idle_pct[ph]);
      end
    end

    start <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** first_fit_free_list_allocator: PASSED **");
    end else begin
      $display("** first_fit_free_list_allocator: FAILED **");
    end
    $finish;
  end

endmodule
